@@ src/ultrasonic_ranger_median3_top_defines.svh @@
// ----------------------------------------------------------------------------
// Ultrasonic ranger assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by arst_n.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGER_MEDIAN3_TOP_DEFINES_SVH
`define ULTRASONIC_RANGER_MEDIAN3_TOP_DEFINES_SVH

// same-cycle implication
`define URM3_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ranger assertion failed (same-cycle implication)");

// next-cycle implication
`define URM3_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ranger assertion failed (next-cycle implication)");

`endif

@@ src/urm3_pkg.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic ranger package
// Types, phase codes and helpers shared by the sequencer and the top level.
// ----------------------------------------------------------------------------
package urm3_pkg;

	localparam int SAMPLES_PER_SENSOR = 3;
	localparam int SENSOR_COUNT       = 3;
	localparam int SETTLE_TICKS       = 2;
	localparam int DIST_MAX           = 2047;

	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_SETTLE    = 3'd1;
	localparam logic [2:0] PH_PULSE     = 3'd2;
	localparam logic [2:0] PH_WAIT_END  = 3'd3;
	localparam logic [2:0] PH_WAIT_HIGH = 3'd4;
	localparam logic [2:0] PH_MEASURE   = 3'd5;

	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_TRIG_W  = 2'd1;
	localparam logic [1:0] REG_SCALE   = 2'd2;

	typedef logic signed [11:0] dist_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [7:0]  trigger_width;
		logic [15:0] scale_q16;
	} urm3_cfg_t;

	// last member sits in the lowest bits
	typedef struct packed {
		dist_t dist_right;
		dist_t dist_center;
		dist_t dist_left;
		logic  done_res;
		logic  busy_res;
		logic  trig_right;
		logic  trig_center;
		logic  trig_left;
	} urm3_res_t;

	function automatic dist_t med3(input dist_t a, input dist_t b, input dist_t c);
		dist_t lo;
		dist_t hi;
		begin
			lo = (a > b) ? b : a;
			hi = (a > b) ? a : b;
			if (c >= hi)
				med3 = hi;
			else if (c <= lo)
				med3 = lo;
			else
				med3 = c;
		end
	endfunction

endpackage

@@ src/urm3_seq.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic ranger sequencer
// Trigger/echo state machine, pulse timing, scaling and median filter.
// One tick is processed per step; res is the result of that tick.
// ----------------------------------------------------------------------------
module urm3_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               start_req,
	input  logic [2:0]         echo,      // left, center, right from bit 0
	input  urm3_pkg::urm3_cfg_t cfg,
	output urm3_pkg::urm3_res_t res
);
	import urm3_pkg::*;

	logic [2:0]  phase_q,   phase_n;
	logic [1:0]  sensor_q,  sensor_n;
	logic [1:0]  sample_q,  sample_n;
	logic [15:0] elapsed_q, elapsed_n;
	logic [15:0] pulse_q,   pulse_n;
	dist_t       hold_q [0:1];
	dist_t       dist_q [0:2];
	dist_t       dist_n [0:2];

	logic        echo_sel;
	logic        fin;
	dist_t       fin_val;
	logic        hold_we;
	logic        done;
	logic [31:0] prod;
	dist_t       meas_dist;
	logic [2:0]  sensor_inc;

	always_comb begin
		case (sensor_q)
			2'd1:    echo_sel = echo[1];
			2'd2:    echo_sel = echo[2];
			default: echo_sel = echo[0];
		endcase
	end

	// cm = (width * scale) >> 16, clipped to the 11-bit range
	assign prod = {16'd0, pulse_q} * {16'd0, cfg.scale_q16};
	assign meas_dist = (prod[31:16] > 16'(DIST_MAX)) ? dist_t'(DIST_MAX)
		: dist_t'({1'b0, prod[26:16]});

	assign sensor_inc = {1'b0, sensor_q} + 3'd1;

	always_comb begin
		phase_n   = phase_q;
		sensor_n  = sensor_q;
		sample_n  = sample_q;
		elapsed_n = elapsed_q;
		pulse_n   = pulse_q;
		fin       = 1'b0;
		fin_val   = meas_dist;
		hold_we   = 1'b0;
		done      = 1'b0;
		for (int i = 0; i < 3; i++)
			dist_n[i] = dist_q[i];

		case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					phase_n   = PH_SETTLE;
					sensor_n  = '0;
					sample_n  = '0;
					pulse_n   = 16'd1;
					elapsed_n = '0;
				end
			end
			PH_SETTLE: begin
				if (pulse_q >= 16'(SETTLE_TICKS)) begin
					phase_n = PH_PULSE;
					pulse_n = 16'd1;
				end else begin
					pulse_n = pulse_q + 16'd1;
				end
			end
			PH_PULSE: begin
				if (pulse_q >= {8'd0, cfg.trigger_width}) begin
					phase_n   = PH_WAIT_END;
					elapsed_n = '0;
					pulse_n   = '0;
				end else begin
					pulse_n = pulse_q + 16'd1;
				end
			end
			PH_WAIT_END, PH_WAIT_HIGH, PH_MEASURE: begin
				elapsed_n = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
				if (phase_q == PH_MEASURE && !echo_sel) begin
					fin = 1'b1;
				end else begin
					if (phase_q == PH_WAIT_END) begin
						if (!echo_sel)
							phase_n = PH_WAIT_HIGH;
					end else if (phase_q == PH_WAIT_HIGH) begin
						if (echo_sel) begin
							phase_n = PH_MEASURE;
							pulse_n = 16'd1;
						end
					end else if (pulse_q != 16'hFFFF) begin
						pulse_n = pulse_q + 16'd1;
					end
					// an echo end on the timeout tick still counts
					if (elapsed_n >= cfg.timeout_ticks) begin
						fin     = 1'b1;
						fin_val = -12'sd1;
					end
				end
			end
			default: begin
				phase_n  = PH_IDLE;
				sensor_n = '0;
				sample_n = '0;
			end
		endcase

		if (fin) begin
			if (sample_q < 2'd2)
				hold_we = 1'b1;
			else if (sensor_q != 2'd3)
				dist_n[sensor_q] = med3(hold_q[0], hold_q[1], fin_val);
			sample_n = sample_q + 2'd1;
			if (sample_n == 2'(SAMPLES_PER_SENSOR)) begin
				sample_n = '0;
				sensor_n = sensor_inc[1:0];
				if (sensor_inc >= 3'(SENSOR_COUNT)) begin
					sensor_n = '0;
					phase_n  = PH_IDLE;
					done     = 1'b1;
				end
			end
			if (!done) begin
				phase_n = PH_SETTLE;
				pulse_n = 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			sensor_q  <= '0;
			sample_q  <= '0;
			elapsed_q <= '0;
			pulse_q   <= '0;
			for (int i = 0; i < 3; i++)
				dist_q[i] <= -12'sd1;
		end else if (step) begin
			phase_q   <= phase_n;
			sensor_q  <= sensor_n;
			sample_q  <= sample_n;
			elapsed_q <= elapsed_n;
			pulse_q   <= pulse_n;
			for (int i = 0; i < 3; i++)
				dist_q[i] <= dist_n[i];
		end
	end

	// first two samples of a sensor, always written before use
	always_ff @(posedge clk) begin
		if (step && hold_we)
			hold_q[sample_q[0]] <= fin_val;
	end

	always_comb begin
		res.trig_left   = (phase_n == PH_PULSE) && (sensor_n == 2'd0);
		res.trig_center = (phase_n == PH_PULSE) && (sensor_n == 2'd1);
		res.trig_right  = (phase_n == PH_PULSE) && (sensor_n == 2'd2);
		res.busy_res    = (phase_n != PH_IDLE);
		res.done_res    = done;
		res.dist_left   = dist_n[0];
		res.dist_center = dist_n[1];
		res.dist_right  = dist_n[2];
	end

endmodule

@@ src/ultrasonic_ranger_median3_top.sv @@
// ----------------------------------------------------------------------------
// Ultrasonic ranger, median of three
// Each stream transaction is one microsecond tick carrying the start request
// and the three echo levels; each tick returns one result transaction with
// the trigger levels, busy, a done pulse and the three median distances.
// One tick is taken per clock cycle when the result side keeps up; a result
// passes through the input register, then the result register, with the
// sequencer step and the 16x16 scaling multiply between them. A stalled
// result register holds the input register, and tready drops only when both
// are full. Registers: timeout_ticks at 0x0, trigger_width at 0x4, scale_q16
// at 0x8; write them only while no tick is in flight.
// ----------------------------------------------------------------------------
`include "ultrasonic_ranger_median3_top_defines.svh"

module ultrasonic_ranger_median3_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // start_req, echo_left, echo_center, echo_right
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // trig_left, trig_center, trig_right, busy_res,
	                               // done_res, dist_left, dist_center, dist_right
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import urm3_pkg::*;

	urm3_cfg_t  cfg_q;
	logic [3:0] in_s1;
	logic       valid_s1;
	logic       m_valid_q;
	urm3_res_t  res_n;
	urm3_res_t  res_q;
	logic       advance;
	logic       cfg_we;

	// ---- configuration ----
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= 16'd10000;
			cfg_q.trigger_width <= 8'd10;
			cfg_q.scale_q16     <= 16'd1124;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_TIMEOUT: cfg_q.timeout_ticks <= pwdata[15:0];
				REG_TRIG_W:  cfg_q.trigger_width <= pwdata[7:0];
				REG_SCALE:   cfg_q.scale_q16     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_TIMEOUT: prdata = {16'd0, cfg_q.timeout_ticks};
			REG_TRIG_W:  prdata = {24'd0, cfg_q.trigger_width};
			REG_SCALE:   prdata = {16'd0, cfg_q.scale_q16};
			default:     prdata = '0;
		endcase
	end

	// ---- tick pipeline ----
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			in_s1 <= s_tdata[3:0];
		if (advance)
			res_q <= res_n;
	end

	urm3_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.start_req (in_s1[0]),
		.echo      (in_s1[3:1]),
		.cfg       (cfg_q),
		.res       (res_n)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, res_q};

	// ---- checks ----
	`URM3_ASSERT_IMPLY(a_trig_onehot, m_valid_q,
		$onehot0({res_q.trig_left, res_q.trig_center, res_q.trig_right}))
	`URM3_ASSERT_IMPLY(a_trig_busy,
		m_valid_q && (res_q.trig_left || res_q.trig_center || res_q.trig_right),
		res_q.busy_res)
	`URM3_ASSERT_IMPLY(a_done_idle, m_valid_q && res_q.done_res, !res_q.busy_res)
	`URM3_ASSERT_IMPLY(a_stall_cause, !s_tready, valid_s1 && m_valid_q && !m_tready)

endmodule
